FILE: sv/json_token_lexer_unit_macros.svh
// Assertion macros shared by the JSON token lexer RTL.
`ifndef JSON_TOKEN_LEXER_UNIT_MACROS_SVH
`define JSON_TOKEN_LEXER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define JTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define JTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/jtl_pkg.sv
// Types, character codes and keyword tables for the JSON token lexer.
package jtl_pkg;

    // Token kinds as they appear on the result channel
    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_LBRACE    = 4'd1,
        KIND_LBRACKET  = 4'd2,
        KIND_RBRACE    = 4'd3,
        KIND_RBRACKET  = 4'd4,
        KIND_COMMA     = 4'd5,
        KIND_COLON     = 4'd6,
        KIND_SEMICOLON = 4'd7,
        KIND_STRING    = 4'd8,
        KIND_NUMBER    = 4'd9,
        KIND_TRUE      = 4'd10,
        KIND_FALSE     = 4'd11,
        KIND_NULL      = 4'd12,
        KIND_INVALID   = 4'd13
    } token_kind_t;

    // Keyword selector
    typedef enum logic [1:0] {
        KW_TRUE  = 2'd0,
        KW_FALSE = 2'd1,
        KW_NULL  = 2'd2
    } kw_sel_t;

    localparam int MAX_TOKENS = 3;

    typedef struct packed {
        token_kind_t kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] line;
    } token_t;

    // All tokens caused by one input byte, packed from slot 0
    typedef struct packed {
        logic [1:0]                  count;
        token_t [MAX_TOKENS-1:0]     tok;
    } bundle_t;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_L         = 8'h6C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_S         = 8'h73;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // Length of a keyword in bytes
    function automatic logic [2:0] kw_len(kw_sel_t k);
        logic [2:0] len;
        len = (k == KW_FALSE) ? 3'd5 : 3'd4;
        return len;
    endfunction

    // Expected byte of a keyword at a given position
    function automatic logic [7:0] kw_char(kw_sel_t k, logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_FALSE:
            begin
                case (idx)
                    3'd0: c = CH_F;
                    3'd1: c = CH_A;
                    3'd2: c = CH_L;
                    3'd3: c = CH_S;
                    3'd4: c = CH_LOWER_E;
                    default: c = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                case (idx)
                    3'd0: c = CH_N;
                    3'd1: c = CH_U;
                    3'd2: c = CH_L;
                    3'd3: c = CH_L;
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: c = CH_T;
                    3'd1: c = CH_R;
                    3'd2: c = CH_U;
                    3'd3: c = CH_LOWER_E;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    // Token kind emitted for a completed keyword
    function automatic token_kind_t kw_kind(kw_sel_t k);
        token_kind_t t;
        case (k)
            KW_FALSE: t = KIND_FALSE;
            KW_NULL:  t = KIND_NULL;
            default:  t = KIND_TRUE;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/jtl_if.sv
// Valid/ready channel interfaces for text bytes in and tokens out.
interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jtl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [31:0] token_line;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output token_line, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input token_line, input last_of_run, output ready
    );
endinterface

FILE: sv/jtl_lexer_core.sv
// Lexer state machine: classifies one byte per beat and registers its token bundle.
`include "json_token_lexer_unit_macros.svh"

module jtl_lexer_core #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    jtl_in_if.sink            char_stream,
    output logic              bundle_valid,
    output jtl_pkg::bundle_t  bundle,
    input  logic              bundle_take
);

    typedef enum logic [8:0] {
        MODE_IDLE  = 9'b000000001,
        MODE_STR   = 9'b000000010,
        MODE_NSIGN = 9'b000000100,
        MODE_NINT  = 9'b000001000,
        MODE_NFRAC = 9'b000010000,
        MODE_EMARK = 9'b000100000,
        MODE_ESIGN = 9'b001000000,
        MODE_EDIG  = 9'b010000000,
        MODE_KW    = 9'b100000000
    } mode_t;

    mode_t                   mode_reg, mode_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [31:0]             line_reg, line_next;
    logic [OFFSET_WIDTH-1:0] pstart_reg, pstart_next;
    logic [31:0]             plen_reg, plen_next;
    logic [2:0]              kw_idx_reg, kw_idx_next;
    jtl_pkg::kw_sel_t        kw_sel_reg, kw_sel_next;
    logic                    pbs_reg, pbs_next;

    logic                    bval_reg, bval_next;
    jtl_pkg::bundle_t        bundle_reg, bundle_next;

    logic                    accept;
    jtl_pkg::token_t [3:0]   tok;
    logic [3:0]              tv;

    // Next mode of a number after one more byte
    function automatic mode_t number_next(mode_t m, logic [7:0] b);
        logic  dig;
        logic  e;
        mode_t nx;
        dig = (b >= jtl_pkg::CH_0) && (b <= jtl_pkg::CH_9);
        e   = (b == jtl_pkg::CH_LOWER_E) || (b == jtl_pkg::CH_UPPER_E);
        case (m)
            MODE_NSIGN: nx = dig ? MODE_NINT : MODE_IDLE;
            MODE_NINT:  nx = dig ? MODE_NINT : (b == jtl_pkg::CH_DOT) ? MODE_NFRAC :
                             e ? MODE_EMARK : MODE_IDLE;
            MODE_NFRAC: nx = dig ? MODE_NFRAC : e ? MODE_EMARK : MODE_IDLE;
            MODE_EMARK: nx = dig ? MODE_EDIG :
                             ((b == jtl_pkg::CH_PLUS) || (b == jtl_pkg::CH_MINUS)) ?
                             MODE_ESIGN : MODE_IDLE;
            MODE_ESIGN: nx = dig ? MODE_EDIG : MODE_IDLE;
            default:    nx = dig ? MODE_EDIG : MODE_IDLE;
        endcase
        return nx;
    endfunction

    function automatic logic is_number(mode_t m);
        return (m == MODE_NSIGN) || (m == MODE_NINT) || (m == MODE_NFRAC) ||
               (m == MODE_EMARK) || (m == MODE_ESIGN) || (m == MODE_EDIG);
    endfunction

    // Build one token; the offset is cut or zero-extended to 32 bits
    function automatic jtl_pkg::token_t mk_token(
        jtl_pkg::token_kind_t    kind,
        logic [OFFSET_WIDTH-1:0] start,
        logic [31:0]             len,
        logic [31:0]             line
    );
        jtl_pkg::token_t t;
        logic [63:0]     wide;
        wide     = 64'(start);
        t.kind   = kind;
        t.start  = wide[31:0];
        t.length = len;
        t.line   = line;
        return t;
    endfunction

    assign char_stream.ready = !bval_reg || bundle_take;
    assign accept            = char_stream.valid && char_stream.ready;
    assign bundle_valid      = bval_reg;
    assign bundle            = bundle_reg;

    // Classify the byte, update the pending token and collect emitted tokens
    always_comb
    begin
        logic [7:0]              b;
        logic [OFFSET_WIDTH-1:0] off_inc;
        logic [31:0]             plen_grow;
        logic [31:0]             line_inc;
        logic                    run_idle;
        mode_t                   nx;
        logic [2:0]              klen;
        logic [2:0]              cnt;

        b         = char_stream.data_byte;
        off_inc   = offset_reg + OFFSET_WIDTH'(1);
        plen_grow = (plen_reg == jtl_pkg::SAT32) ? plen_reg : plen_reg + 32'd1;
        line_inc  = (line_reg == jtl_pkg::SAT32) ? line_reg : line_reg + 32'd1;
        run_idle  = 1'b0;
        nx        = MODE_IDLE;
        klen      = jtl_pkg::kw_len(kw_sel_reg);

        mode_next   = mode_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        kw_idx_next = kw_idx_reg;
        kw_sel_next = kw_sel_reg;
        pbs_next    = pbs_reg;

        tv  = '0;
        tok = '0;

        // Advance the pending token, close it when the byte ends it
        unique case (mode_reg) inside
            MODE_STR:
            begin
                if ((b == jtl_pkg::CH_QUOTE) && !pbs_reg)
                begin
                    tv[0]     = 1'b1;
                    tok[0]    = mk_token(jtl_pkg::KIND_STRING, pstart_reg, plen_reg, line_reg);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    plen_next = plen_grow;
                    pbs_next  = (b == jtl_pkg::CH_BSLASH) && !pbs_reg;
                end
            end
            MODE_NSIGN, MODE_NINT, MODE_NFRAC, MODE_EMARK, MODE_ESIGN, MODE_EDIG:
            begin
                nx = number_next(mode_reg, b);
                if (nx != MODE_IDLE)
                begin
                    mode_next = nx;
                    plen_next = plen_grow;
                end
                else
                begin
                    tv[0]     = 1'b1;
                    tok[0]    = mk_token(jtl_pkg::KIND_NUMBER, pstart_reg, plen_reg, line_reg);
                    mode_next = MODE_IDLE;
                    run_idle  = 1'b1;
                end
            end
            MODE_KW:
            begin
                if ((kw_idx_reg < klen) && (b == jtl_pkg::kw_char(kw_sel_reg, kw_idx_reg)))
                begin
                    plen_next   = plen_grow;
                    kw_idx_next = kw_idx_reg + 3'd1;
                    if ((4'(kw_idx_reg) + 4'd1) >= 4'(klen))
                    begin
                        tv[0]     = 1'b1;
                        tok[0]    = mk_token(jtl_pkg::kw_kind(kw_sel_reg), pstart_reg,
                                             plen_grow, line_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                else
                begin
                    tv[0]     = 1'b1;
                    tok[0]    = mk_token(jtl_pkg::KIND_INVALID, pstart_reg, plen_reg, line_reg);
                    mode_next = MODE_IDLE;
                    run_idle  = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // Lex the byte between tokens
        if (run_idle)
        begin
            case (b) inside
                jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_VT, jtl_pkg::CH_FF,
                jtl_pkg::CH_CR:
                begin
                end
                jtl_pkg::CH_NL:
                begin
                    line_next = line_inc;
                end
                jtl_pkg::CH_LBRACE:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_LBRACE, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_LBRACKET:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_LBRACKET, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_RBRACE:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_RBRACE, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_RBRACKET:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_RBRACKET, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_COMMA:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_COMMA, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_COLON:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_COLON, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_SEMICOLON:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_SEMICOLON, offset_reg, 32'd1, line_reg);
                end
                jtl_pkg::CH_QUOTE:
                begin
                    mode_next   = MODE_STR;
                    pstart_next = off_inc;
                    plen_next   = 32'd0;
                    pbs_next    = 1'b0;
                end
                jtl_pkg::CH_MINUS:
                begin
                    mode_next   = MODE_NSIGN;
                    pstart_next = offset_reg;
                    plen_next   = 32'd1;
                end
                jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N:
                begin
                    mode_next   = MODE_KW;
                    pstart_next = offset_reg;
                    plen_next   = 32'd1;
                    kw_idx_next = 3'd1;
                    kw_sel_next = (b == jtl_pkg::CH_T) ? jtl_pkg::KW_TRUE :
                                  (b == jtl_pkg::CH_F) ? jtl_pkg::KW_FALSE : jtl_pkg::KW_NULL;
                end
                [jtl_pkg::CH_0:jtl_pkg::CH_9]:
                begin
                    mode_next   = MODE_NINT;
                    pstart_next = offset_reg;
                    plen_next   = 32'd1;
                end
                default:
                begin
                    tv[1]  = 1'b1;
                    tok[1] = mk_token(jtl_pkg::KIND_INVALID, offset_reg, 32'd1, line_reg);
                end
            endcase
        end

        // Flush on the final byte, then drop back to the start of a new text
        if (char_stream.end_of_input)
        begin
            if (mode_next == MODE_STR)
            begin
                tv[2]  = 1'b1;
                tok[2] = mk_token(jtl_pkg::KIND_STRING, pstart_next, plen_next, line_next);
            end
            else if (is_number(mode_next))
            begin
                tv[2]  = 1'b1;
                tok[2] = mk_token(jtl_pkg::KIND_NUMBER, pstart_next, plen_next, line_next);
            end
            else if (mode_next == MODE_KW)
            begin
                tv[2]  = 1'b1;
                tok[2] = mk_token(jtl_pkg::KIND_INVALID, pstart_next, plen_next, line_next);
            end
            tv[3]  = 1'b1;
            tok[3] = mk_token(jtl_pkg::KIND_END, off_inc, 32'd0, line_next);

            mode_next   = MODE_IDLE;
            offset_next = '0;
            line_next   = 32'd1;
            pstart_next = '0;
            plen_next   = 32'd0;
            kw_idx_next = 3'd0;
            kw_sel_next = jtl_pkg::KW_TRUE;
            pbs_next    = 1'b0;
        end
        else
        begin
            offset_next = off_inc;
        end

        // Pack the emitted tokens into consecutive slots
        cnt         = 3'd0;
        bundle_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (tv[i])
            begin
                if (cnt < 3'(jtl_pkg::MAX_TOKENS))
                begin
                    bundle_next.tok[cnt[1:0]] = tok[i];
                end
                cnt = cnt + 3'd1;
            end
        end
        bundle_next.count = cnt[1:0];
    end

    // Bundle slot: free when taken, filled by a beat that emits tokens
    always_comb
    begin
        bval_next = bval_reg && !bundle_take;
        if (accept && (bundle_next.count != 2'd0))
        begin
            bval_next = 1'b1;
        end
    end

    // Lexer state and bundle valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            line_reg   <= 32'd1;
            pstart_reg <= '0;
            plen_reg   <= 32'd0;
            kw_idx_reg <= 3'd0;
            kw_sel_reg <= jtl_pkg::KW_TRUE;
            pbs_reg    <= 1'b0;
            bval_reg   <= 1'b0;
        end
        else
        begin
            bval_reg <= bval_next;
            if (accept)
            begin
                mode_reg   <= mode_next;
                offset_reg <= offset_next;
                line_reg   <= line_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                kw_idx_reg <= kw_idx_next;
                kw_sel_reg <= kw_sel_next;
                pbs_reg    <= pbs_next;
            end
        end
    end

    // Bundle payload
    always_ff @(posedge clk)
    begin
        if (accept && (bundle_next.count != 2'd0))
        begin
            bundle_reg <= bundle_next;
        end
    end

    `JTL_ASSERT_NXT(a_end_restarts, clk, rst_n, accept && char_stream.end_of_input, (offset_reg == '0) && (line_reg == 32'd1) && (mode_reg == MODE_IDLE), "final byte did not restart the lexer")
    `JTL_ASSERT_IMP(a_line_nonzero, clk, rst_n, 1'b1, line_reg != 32'd0, "line count reached zero")

endmodule

FILE: sv/jtl_token_serializer.sv
// Output stage: holds one token bundle and sends its tokens one beat at a time.
`include "json_token_lexer_unit_macros.svh"

module jtl_token_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bundle_valid,
    input  jtl_pkg::bundle_t  bundle,
    output logic              bundle_take,
    jtl_out_if.source         token_stream
);

    jtl_pkg::bundle_t hold_reg;
    logic [1:0]       idx_reg, idx_next;
    logic             active_reg, active_next;
    logic             last_tok;
    logic             finishing;
    jtl_pkg::token_t  cur;

    assign cur       = hold_reg.tok[idx_reg];
    assign last_tok  = (idx_reg == (hold_reg.count - 2'd1));
    assign finishing = active_reg && token_stream.ready && last_tok;
    assign bundle_take = bundle_valid && (!active_reg || finishing);

    // Drive the current token
    assign token_stream.valid        = active_reg;
    assign token_stream.token_kind   = cur.kind;
    assign token_stream.token_start  = cur.start;
    assign token_stream.token_length = cur.length;
    assign token_stream.token_line   = cur.line;
    assign token_stream.last_of_run  = last_tok;

    // Load a new bundle or advance through the held one
    always_comb
    begin
        idx_next    = idx_reg;
        active_next = active_reg;
        if (bundle_take)
        begin
            idx_next    = 2'd0;
            active_next = 1'b1;
        end
        else if (active_reg && token_stream.ready)
        begin
            if (last_tok)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 2'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

    // Hold the bundle payload
    always_ff @(posedge clk)
    begin
        if (bundle_take)
        begin
            hold_reg <= bundle;
        end
    end

    `JTL_ASSERT_IMP(a_end_is_last, clk, rst_n, token_stream.valid && (token_stream.token_kind == jtl_pkg::KIND_END), token_stream.last_of_run, "end token not last of its run")
    `JTL_ASSERT_IMP(a_idx_in_range, clk, rst_n, active_reg, idx_reg < hold_reg.count, "token index beyond bundle count")

endmodule

FILE: sv/json_token_lexer_unit.sv
// Each token is registered in bundle_reg, then in the serializer's hold_reg.
// Throughput: one byte per cycle while each byte gives at most one token and the
// output is ready; a byte with more tokens holds the single-token port till all are sent.
// Reset (rst_n, async, active low): lexer idle, offset 0, line 1, stages empty.
// Top level of the JSON token lexer: lexer core followed by the token serializer.
module json_token_lexer_unit #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    jtl_in_if.sink     char_stream,
    jtl_out_if.source  token_stream
);

    logic             bundle_valid;
    logic             bundle_take;
    jtl_pkg::bundle_t bundle;

    // Classify bytes and register their tokens
    jtl_lexer_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_stream  (char_stream),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .bundle_take  (bundle_take)
    );

    // Send tokens one beat at a time
    jtl_token_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .bundle_take  (bundle_take),
        .token_stream (token_stream)
    );

endmodule

FILE: bench/tb_json_token_lexer_unit.sv
// Self-checking bench for the JSON token lexer: random JSON-like text in, token beats checked out.
module tb_json_token_lexer_unit;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int TEXT_BYTES   = 160;

    // Receiver ready patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_STALLS = 2;
    localparam int RX_TOGGLE = 3;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NSIGN,
        MODE_NINT,
        MODE_NFRAC,
        MODE_EMARK,
        MODE_ESIGN,
        MODE_EDIG,
        MODE_KEYWORD
    } lex_mode_t;

    typedef struct packed {
        jtl_pkg::token_kind_t kind;
        logic [31:0]          start;
        logic [31:0]          length;
        logic [31:0]          line;
        logic                 last;
    } token_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } byte_beat_t;

    // Token predictor and store of the token beats still owed by the block
    class lexer_token_board;
        lex_mode_t            mode;
        logic [31:0]          byte_offset;
        logic [31:0]          line_count;
        logic [31:0]          pend_start;
        logic [31:0]          pend_length;
        logic [2:0]           kw_index;
        jtl_pkg::kw_sel_t     kw_sel;
        logic                 after_bslash;
        string                kw_spell [3];
        jtl_pkg::token_kind_t kw_token [3];
        token_beat_t          run_tokens[$];
        token_beat_t          pending_tokens[$];
        int                   errors;

        function new();
            kw_spell[0] = "true";
            kw_spell[1] = "false";
            kw_spell[2] = "null";
            kw_token[0] = jtl_pkg::KIND_TRUE;
            kw_token[1] = jtl_pkg::KIND_FALSE;
            kw_token[2] = jtl_pkg::KIND_NULL;
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode         = MODE_IDLE;
            byte_offset  = 32'd0;
            line_count   = 32'd1;
            pend_start   = 32'd0;
            pend_length  = 32'd0;
            kw_index     = 3'd0;
            kw_sel       = jtl_pkg::KW_TRUE;
            after_bslash = 1'b0;
        endfunction

        function int outstanding();
            return pending_tokens.size();
        endfunction

        // Queue a token of the current byte, dropping any beyond the port's limit
        function void add_token(jtl_pkg::token_kind_t kind, logic [31:0] start,
                                logic [31:0] len);
            token_beat_t t;
            if (run_tokens.size() < jtl_pkg::MAX_TOKENS)
            begin
                t.kind   = kind;
                t.start  = start;
                t.length = len;
                t.line   = line_count;
                t.last   = 1'b0;
                run_tokens.push_back(t);
            end
        endfunction

        function void hold_pending(lex_mode_t m, logic [31:0] start, logic [31:0] len);
            mode        = m;
            pend_start  = start;
            pend_length = len;
        endfunction

        function void grow_pending();
            if (pend_length != jtl_pkg::SAT32)
                pend_length++;
        endfunction

        // Lex a byte that arrives between tokens
        function void lex_idle(logic [7:0] b, logic [31:0] off);
            case (b)
                jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_VT, jtl_pkg::CH_FF,
                jtl_pkg::CH_CR:
                begin
                end
                jtl_pkg::CH_NL:
                begin
                    if (line_count != jtl_pkg::SAT32)
                        line_count++;
                end
                jtl_pkg::CH_LBRACE:    add_token(jtl_pkg::KIND_LBRACE, off, 32'd1);
                jtl_pkg::CH_LBRACKET:  add_token(jtl_pkg::KIND_LBRACKET, off, 32'd1);
                jtl_pkg::CH_RBRACE:    add_token(jtl_pkg::KIND_RBRACE, off, 32'd1);
                jtl_pkg::CH_RBRACKET:  add_token(jtl_pkg::KIND_RBRACKET, off, 32'd1);
                jtl_pkg::CH_COMMA:     add_token(jtl_pkg::KIND_COMMA, off, 32'd1);
                jtl_pkg::CH_COLON:     add_token(jtl_pkg::KIND_COLON, off, 32'd1);
                jtl_pkg::CH_SEMICOLON: add_token(jtl_pkg::KIND_SEMICOLON, off, 32'd1);
                jtl_pkg::CH_QUOTE:
                begin
                    hold_pending(MODE_STRING, off + 32'd1, 32'd0);
                    after_bslash = 1'b0;
                end
                jtl_pkg::CH_MINUS:     hold_pending(MODE_NSIGN, off, 32'd1);
                jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N:
                begin
                    hold_pending(MODE_KEYWORD, off, 32'd1);
                    kw_sel   = (b == jtl_pkg::CH_T) ? jtl_pkg::KW_TRUE :
                               (b == jtl_pkg::CH_F) ? jtl_pkg::KW_FALSE : jtl_pkg::KW_NULL;
                    kw_index = 3'd1;
                end
                default:
                begin
                    if (b >= jtl_pkg::CH_0 && b <= jtl_pkg::CH_9)
                        hold_pending(MODE_NINT, off, 32'd1);
                    else
                        add_token(jtl_pkg::KIND_INVALID, off, 32'd1);
                end
            endcase
        endfunction

        // Next number mode for a byte, or idle when the byte ends the number
        function lex_mode_t number_step(lex_mode_t m, logic [7:0] b);
            logic      dig;
            logic      emark;
            lex_mode_t nx;
            dig   = (b >= jtl_pkg::CH_0 && b <= jtl_pkg::CH_9);
            emark = (b == jtl_pkg::CH_LOWER_E || b == jtl_pkg::CH_UPPER_E);
            case (m)
                MODE_NSIGN: nx = dig ? MODE_NINT : MODE_IDLE;
                MODE_NINT:
                    nx = dig ? MODE_NINT : (b == jtl_pkg::CH_DOT) ? MODE_NFRAC :
                         emark ? MODE_EMARK : MODE_IDLE;
                MODE_NFRAC: nx = dig ? MODE_NFRAC : emark ? MODE_EMARK : MODE_IDLE;
                MODE_EMARK:
                    nx = dig ? MODE_EDIG :
                         (b == jtl_pkg::CH_PLUS || b == jtl_pkg::CH_MINUS) ? MODE_ESIGN :
                         MODE_IDLE;
                MODE_ESIGN: nx = dig ? MODE_EDIG : MODE_IDLE;
                default:    nx = dig ? MODE_EDIG : MODE_IDLE;
            endcase
            return nx;
        endfunction

        // Predict the tokens of one accepted byte
        function void note_byte(logic [7:0] b, logic eoi);
            logic [31:0] off;
            lex_mode_t   nx;
            token_beat_t t;
            int          k;
            run_tokens.delete();
            off = byte_offset;
            k   = int'(kw_sel);
            if (mode == MODE_STRING)
            begin
                if (b == jtl_pkg::CH_QUOTE && !after_bslash)
                begin
                    add_token(jtl_pkg::KIND_STRING, pend_start, pend_length);
                    mode = MODE_IDLE;
                end
                else
                begin
                    grow_pending();
                    after_bslash = (b == jtl_pkg::CH_BSLASH) && !after_bslash;
                end
            end
            else if (mode >= MODE_NSIGN && mode <= MODE_EDIG)
            begin
                nx = number_step(mode, b);
                if (nx != MODE_IDLE)
                begin
                    mode = nx;
                    grow_pending();
                end
                else
                begin
                    add_token(jtl_pkg::KIND_NUMBER, pend_start, pend_length);
                    mode = MODE_IDLE;
                    lex_idle(b, off);
                end
            end
            else if (mode == MODE_KEYWORD)
            begin
                if (kw_index < kw_spell[k].len() && b == kw_spell[k][kw_index])
                begin
                    grow_pending();
                    kw_index++;
                    if (kw_index >= kw_spell[k].len())
                    begin
                        add_token(kw_token[k], pend_start, pend_length);
                        mode = MODE_IDLE;
                    end
                end
                else
                begin
                    add_token(jtl_pkg::KIND_INVALID, pend_start, pend_length);
                    mode = MODE_IDLE;
                    lex_idle(b, off);
                end
            end
            else
            begin
                mode = MODE_IDLE;
                lex_idle(b, off);
            end

            // Flush the pending token and close the text on its final byte
            if (eoi)
            begin
                if (mode == MODE_STRING)
                    add_token(jtl_pkg::KIND_STRING, pend_start, pend_length);
                else if (mode >= MODE_NSIGN && mode <= MODE_EDIG)
                    add_token(jtl_pkg::KIND_NUMBER, pend_start, pend_length);
                else if (mode == MODE_KEYWORD)
                    add_token(jtl_pkg::KIND_INVALID, pend_start, pend_length);
                add_token(jtl_pkg::KIND_END, off + 32'd1, 32'd0);
                clear_state();
            end
            else
                byte_offset = off + 32'd1;

            foreach (run_tokens[i])
            begin
                t      = run_tokens[i];
                t.last = (i == run_tokens.size() - 1);
                pending_tokens.push_back(t);
            end
        endfunction

        // Compare one token beat with the oldest prediction
        function void check_token(logic [3:0] kind, logic [31:0] start, logic [31:0] len,
                                  logic [31:0] line, logic last);
            token_beat_t e;
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token kind %0d start %0d length %0d line %0d last %0d",
                         $time, kind, start, len, line, last);
                errors++;
                return;
            end
            e = pending_tokens.pop_front();
            if (kind !== e.kind || start !== e.start || len !== e.length ||
                line !== e.line || last !== e.last)
            begin
                $display("%0t: token mismatch expected kind %0d start %0d length %0d line %0d last %0d",
                         $time, e.kind, e.start, e.length, e.line, e.last);
                $display("%0t:                  actual kind %0d start %0d length %0d line %0d last %0d",
                         $time, kind, start, len, line, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_cycles = 0;

    jtl_in_if  char_stream();
    jtl_out_if token_stream();

    lexer_token_board board;
    byte_beat_t       text_beats[$];

    json_token_lexer_unit #(
        .OFFSET_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_stream(char_stream),
        .token_stream(token_stream)
    );

    always #5 clk = ~clk;

    // Text building
    function automatic void put_byte(logic [7:0] b);
        byte_beat_t bb;
        bb.data = b;
        bb.eoi  = 1'b0;
        text_beats.push_back(bb);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    function automatic void close_text();
        text_beats[text_beats.size() - 1].eoi = 1'b1;
    endfunction

    function automatic void put_digits(int n);
        repeat (n)
            put_byte(jtl_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    // Append one random fragment: mostly well-formed tokens, some broken ones and noise
    function automatic void put_fragment();
        string kw;
        int    cut;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 6))
                    0: put_byte(jtl_pkg::CH_LBRACE);
                    1: put_byte(jtl_pkg::CH_LBRACKET);
                    2: put_byte(jtl_pkg::CH_RBRACE);
                    3: put_byte(jtl_pkg::CH_RBRACKET);
                    4: put_byte(jtl_pkg::CH_COMMA);
                    5: put_byte(jtl_pkg::CH_COLON);
                    default: put_byte(jtl_pkg::CH_SEMICOLON);
                endcase
            end
            2:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 5))
                        0: put_byte(jtl_pkg::CH_SPACE);
                        1: put_byte(jtl_pkg::CH_TAB);
                        2: put_byte(jtl_pkg::CH_CR);
                        3: put_byte(jtl_pkg::CH_VT);
                        4: put_byte(jtl_pkg::CH_FF);
                        default: put_byte(jtl_pkg::CH_NL);
                    endcase
                end
            end
            3, 4:
            begin
                put_byte(jtl_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            put_byte(jtl_pkg::CH_BSLASH);
                            put_byte(jtl_pkg::CH_QUOTE);
                        end
                        1:
                        begin
                            put_byte(jtl_pkg::CH_BSLASH);
                            put_byte(jtl_pkg::CH_BSLASH);
                        end
                        2: put_byte(jtl_pkg::CH_NL);
                        3: put_byte(8'($urandom_range(0, 255)));
                        default: put_byte(8'($urandom_range(8'h23, 8'h7E)));
                    endcase
                end
                // leave a string open now and then
                if ($urandom_range(0, 7) != 0)
                    put_byte(jtl_pkg::CH_QUOTE);
            end
            5, 6:
            begin
                if ($urandom_range(0, 2) == 0)
                    put_byte(jtl_pkg::CH_MINUS);
                put_digits(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
                if ($urandom_range(0, 2) == 0)
                begin
                    put_byte(jtl_pkg::CH_DOT);
                    put_digits($urandom_range(0, 2));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    put_byte($urandom_range(0, 1) ? jtl_pkg::CH_LOWER_E : jtl_pkg::CH_UPPER_E);
                    case ($urandom_range(0, 2))
                        0: put_byte(jtl_pkg::CH_PLUS);
                        1: put_byte(jtl_pkg::CH_MINUS);
                        default:
                        begin
                        end
                    endcase
                    put_digits($urandom_range(0, 2));
                end
            end
            7, 8:
            begin
                case ($urandom_range(0, 2))
                    0: kw = "true";
                    1: kw = "false";
                    default: kw = "null";
                endcase
                if ($urandom_range(0, 3) != 0)
                    put_text(kw);
                else
                begin
                    // break the keyword part way
                    cut = $urandom_range(1, kw.len() - 1);
                    put_text(kw.substr(0, cut - 1));
                    put_byte(8'($urandom_range(0, 255)));
                end
            end
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Push the text one beat at a time, in bursts with random gaps
    task automatic drive_bytes();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (text_beats[i])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap > 0)
                begin
                    char_stream.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
                             $urandom_range(1, 10);
            end
            char_stream.valid        <= 1'b1;
            char_stream.data_byte    <= text_beats[i].data;
            char_stream.end_of_input <= text_beats[i].eoi;
            @(posedge clk);
            while (!char_stream.ready)
                @(posedge clk);
            board.note_byte(text_beats[i].data, text_beats[i].eoi);
            burst_left--;
            @(negedge clk);
        end
        char_stream.valid <= 1'b0;
    endtask

    // Stall the token side on a randomly chosen ready pattern
    initial
    begin
        int rx_tick;
        int rx_mode;
        int stall_left;
        rx_tick            = 0;
        rx_mode            = RX_OPEN;
        stall_left         = 0;
        token_stream.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (rx_tick % 50 == 0)
                rx_mode = $urandom_range(RX_OPEN, RX_TOGGLE);
            case (rx_mode)
                RX_OPEN:   token_stream.ready <= 1'b1;
                RX_RANDOM: token_stream.ready <= ($urandom_range(0, 9) < 7);
                RX_STALLS:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        token_stream.ready <= 1'b0;
                    end
                    else
                    begin
                        token_stream.ready <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(2, 8);
                    end
                end
                default:   token_stream.ready <= rx_tick[0];
            endcase
        end
    end

    // Check every accepted token beat
    always @(posedge clk)
    begin
        if (rst_n && token_stream.valid && token_stream.ready)
            board.check_token(token_stream.token_kind, token_stream.token_start,
                              token_stream.token_length, token_stream.token_line,
                              token_stream.last_of_run);
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((char_stream.valid && char_stream.ready) ||
            (token_stream.valid && token_stream.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d tokens still owed",
                     $time, idle_cycles, board.outstanding());
            $display("tb_json_token_lexer_unit: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        board                    = new();
        rst_n                    = 1'b0;
        char_stream.valid        = 1'b0;
        char_stream.data_byte    = 8'h00;
        char_stream.end_of_input = 1'b0;

        // Directed text: punctuation, escaped quote, full number, broken keyword,
        // newline, extreme bytes, and an unfinished number closed by end of input
        put_text("{\"a\\\"\":-1.2E+3,nux];\n");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_text("1e");
        close_text();

        // Random texts, each closed by an end-of-input beat
        while (text_beats.size() < TEXT_BYTES)
        begin
            repeat ($urandom_range(1, 10))
                put_fragment();
            close_text();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        drive_bytes();

        // Drain the token side
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.outstanding() == 0)
        begin
            $display("tb_json_token_lexer_unit: done, clean");
        end
        else
        begin
            $display("tb_json_token_lexer_unit: done, errors");
        end
        $finish;
    end

endmodule
